/* rtl/core/rtcsm_pkg.sv */
// Shared types, command codes and command byte encoding for the RTC serial master.
package rtcsm_pkg;

   typedef enum logic [1:0] {
      CMD_SINGLE_READ  = 2'd0,
      CMD_SINGLE_WRITE = 2'd1,
      CMD_BURST_READ   = 2'd2,
      CMD_BURST_WRITE  = 2'd3
   } cmd_type;

   localparam logic [7:0] SINGLE_READ_BASE  = 8'h81;
   localparam logic [7:0] SINGLE_WRITE_BASE = 8'h80;
   localparam logic [7:0] BURST_READ_BYTE   = 8'hBF;
   localparam logic [7:0] BURST_WRITE_BYTE  = 8'hBE;

   typedef struct packed {
      logic       active;
      cmd_type    op;
      logic       phase;
      logic [2:0] bit_cnt;
      logic [3:0] byte_cnt;
      logic [7:0] tx;
      logic [7:0] rx;
   } state_type;

   typedef struct packed {
      logic       chip_enable;
      logic       sclk;
      logic       io_out;
      logic       io_drive;
      logic       busy_res;
      logic       data_take;
      logic [7:0] rdata;
      logic       rdata_valid;
      logic [2:0] byte_index;
      logic       done_res;
   } rsp_type;

   function automatic logic [7:0] command_byte(input cmd_type op, input logic [4:0] addr);
      logic [7:0] cb;
      case (op)
         CMD_SINGLE_READ:  cb = {2'b00, addr, 1'b0} | SINGLE_READ_BASE;
         CMD_SINGLE_WRITE: cb = {2'b00, addr, 1'b0} | SINGLE_WRITE_BASE;
         CMD_BURST_READ:   cb = BURST_READ_BYTE;
         default:          cb = BURST_WRITE_BYTE;
      endcase
      return cb;
   endfunction

endpackage

/* rtl/core/rtcsm_if.sv */
// Request and response channel interfaces of the RTC serial master.
interface rtcsm_req_if;
   logic       valid;
   logic       ready;
   logic       start_req;
   logic [1:0] cmd;
   logic [4:0] reg_addr;
   logic [7:0] wdata;
   logic       io_in;

   modport source (output valid, start_req, cmd, reg_addr, wdata, io_in, input ready);
   modport sink   (input valid, start_req, cmd, reg_addr, wdata, io_in, output ready);
endinterface

interface rtcsm_rsp_if;
   logic       valid;
   logic       ready;
   logic       chip_enable;
   logic       sclk;
   logic       io_out;
   logic       io_drive;
   logic       busy_res;
   logic       data_take;
   logic [7:0] rdata;
   logic       rdata_valid;
   logic [2:0] byte_index;
   logic       done_res;

   modport source (output valid, chip_enable, sclk, io_out, io_drive, busy_res, data_take,
                   rdata, rdata_valid, byte_index, done_res, input ready);
   modport sink   (input valid, chip_enable, sclk, io_out, io_drive, busy_res, data_take,
                   rdata, rdata_valid, byte_index, done_res, output ready);
endinterface

/* rtl/core/rtcsm_step.sv */
// Per-tick next-state and line-level logic of the RTC serial master.
module rtcsm_step #(
   parameter int BURST_BYTES = 8
) (
   input  rtcsm_pkg::state_type state_ff,
   input  logic                 start_req,
   input  logic [1:0]           cmd,
   input  logic [4:0]           reg_addr,
   input  logic [7:0]           wdata,
   input  logic                 io_in,
   output rtcsm_pkg::state_type state_in,
   output rtcsm_pkg::rsp_type   rsp_in
);
   localparam logic [3:0] BurstTotal = 4'(BURST_BYTES);

   always_comb begin
      rtcsm_pkg::state_type s;
      logic [3:0]           total;
      logic                 reading;
      s        = state_ff;
      rsp_in   = '0;
      state_in = state_ff;
      total    = 4'd1;
      reading  = 1'b0;
      if (state_ff.active || start_req) begin
         if (!state_ff.active) begin
            s.active   = 1'b1;
            s.op       = rtcsm_pkg::cmd_type'(cmd);
            s.phase    = 1'b0;
            s.bit_cnt  = 3'd0;
            s.byte_cnt = 4'd0;
            s.tx       = rtcsm_pkg::command_byte(rtcsm_pkg::cmd_type'(cmd), reg_addr);
            s.rx       = 8'd0;
         end
         total = s.op[1] ? BurstTotal : 4'd1;
         if (s.byte_cnt > total) begin
            // close: enable low on the closing tick
            s.active        = 1'b0;
            s.phase         = 1'b0;
            s.bit_cnt       = 3'd0;
            s.byte_cnt      = 4'd0;
            rsp_in.done_res = 1'b1;
         end else begin
            rsp_in.chip_enable = 1'b1;
            rsp_in.busy_res    = 1'b1;
            rsp_in.byte_index  = (s.byte_cnt != 4'd0) ? 3'(s.byte_cnt - 4'd1) : 3'd0;
            reading = (s.byte_cnt != 4'd0) && !s.op[0];
            if (!s.phase) begin
               if (!reading && s.byte_cnt != 4'd0 && s.bit_cnt == 3'd0) begin
                  s.tx             = wdata;
                  rsp_in.data_take = 1'b1;
               end
               if (reading) begin
                  if (s.bit_cnt == 3'd0) begin
                     s.rx = 8'd0;
                  end
                  s.rx[s.bit_cnt] = io_in;
               end
            end
            if (!reading) begin
               rsp_in.io_drive = 1'b1;
               rsp_in.io_out   = s.tx[s.bit_cnt];
            end
            if (!s.phase) begin
               s.phase = 1'b1;
            end else begin
               rsp_in.sclk = 1'b1;
               s.phase     = 1'b0;
               if (s.bit_cnt == 3'd7) begin
                  s.bit_cnt = 3'd0;
                  if (reading) begin
                     rsp_in.rdata       = s.rx;
                     rsp_in.rdata_valid = 1'b1;
                  end
                  s.byte_cnt = s.byte_cnt + 4'd1;
               end else begin
                  s.bit_cnt = s.bit_cnt + 3'd1;
               end
            end
         end
         state_in = s;
      end
   end

endmodule

/* rtl/core/three_wire_rtc_serial_master.sv */
// Top level of the three-wire RTC serial master.
// The response of an accepted request is on the output register in the next cycle.
// Throughput: one request per cycle while the response side is ready; the response register frees the input side
// as soon as the held response is taken.
// Reset: synchronous, active high; clears the transaction state to idle and
// empties the response register.
module three_wire_rtc_serial_master #(
   parameter int BURST_BYTES = 8
) (
   input logic          clock,
   input logic          reset,
   rtcsm_req_if.sink    req,
   rtcsm_rsp_if.source  rsp
);
   rtcsm_pkg::state_type state_ff;
   rtcsm_pkg::state_type state_in;
   rtcsm_pkg::rsp_type   rsp_ff;
   rtcsm_pkg::rsp_type   rsp_in;
   logic                 rsp_valid_ff;
   logic                 req_accept;

   assign req.ready  = !rsp_valid_ff || rsp.ready;
   assign req_accept = req.valid && req.ready;

   rtcsm_step #(
      .BURST_BYTES (BURST_BYTES)
   ) u_step (
      .state_ff  (state_ff),
      .start_req (req.start_req),
      .cmd       (req.cmd),
      .reg_addr  (req.reg_addr),
      .wdata     (req.wdata),
      .io_in     (req.io_in),
      .state_in  (state_in),
      .rsp_in    (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (req_accept) begin
         state_ff     <= state_in;
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.chip_enable = rsp_ff.chip_enable;
   assign rsp.sclk        = rsp_ff.sclk;
   assign rsp.io_out      = rsp_ff.io_out;
   assign rsp.io_drive    = rsp_ff.io_drive;
   assign rsp.busy_res    = rsp_ff.busy_res;
   assign rsp.data_take   = rsp_ff.data_take;
   assign rsp.rdata       = rsp_ff.rdata;
   assign rsp.rdata_valid = rsp_ff.rdata_valid;
   assign rsp.byte_index  = rsp_ff.byte_index;
   assign rsp.done_res    = rsp_ff.done_res;

endmodule

/* rtl/core/rtcsm_checker.sv */
// Port-level assertions for the RTC serial master and their bind.
module rtcsm_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       chip_enable,
   input logic       sclk,
   input logic       io_drive,
   input logic       busy_res,
   input logic       data_take,
   input logic       rdata_valid,
   input logic [7:0] rdata,
   input logic       done_res
);

   // hold a stalled response
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rdata) && $stable(sclk)
         && $stable(chip_enable) && $stable(done_res))
      else $error("stalled response changed");

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && done_res |-> !chip_enable && !sclk && !io_drive && !busy_res)
      else $error("closing tick with lines active");

   a_rdata_edge: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rdata_valid |-> sclk && !io_drive && chip_enable)
      else $error("read byte outside clock-high read tick");

   a_take_low: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && data_take |-> !sclk && io_drive && busy_res)
      else $error("write byte taken outside clock-low drive tick");

   a_busy_enable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy_res == chip_enable)
      else $error("busy and chip enable disagree");

endmodule

bind three_wire_rtc_serial_master rtcsm_checker u_rtcsm_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp.valid),
   .rsp_ready   (rsp.ready),
   .chip_enable (rsp.chip_enable),
   .sclk        (rsp.sclk),
   .io_drive    (rsp.io_drive),
   .busy_res    (rsp.busy_res),
   .data_take   (rsp.data_take),
   .rdata_valid (rsp.rdata_valid),
   .rdata       (rsp.rdata),
   .done_res    (rsp.done_res)
);
